// ----- hdl/tss_pkg.sv -----
// package with types and constants of the time source selector
package tss_pkg;

  localparam logic [1:0] CMD_REGISTER = 2'd0;
  localparam logic [1:0] CMD_OBSERVE  = 2'd1;
  localparam logic [1:0] CMD_TICK     = 2'd2;
  localparam logic [1:0] CMD_RESERVED = 2'd3;

  localparam logic [1:0] ST_UNAVAILABLE = 2'd0;
  localparam logic [1:0] ST_UNLOCKED    = 2'd1;
  localparam logic [1:0] ST_HOLDOVER    = 2'd2;
  localparam logic [1:0] ST_LOCKED      = 2'd3;
  localparam logic [1:0] SRC_PTP        = 2'd1;
  localparam logic [1:0] SRC_EXTERNAL   = 2'd2;

  localparam logic [1:0] HEALTH_OK       = 2'd0;
  localparam logic [1:0] HEALTH_WARNING  = 2'd1;
  localparam logic [1:0] HEALTH_DEGRADED = 2'd2;

  localparam logic [0:0] CFG_TIMEOUT = 1'b0;
  localparam logic [0:0] CFG_DISC    = 1'b1;

  localparam logic [15:0] DEFAULT_PERIOD_MS   = 16'd1000;
  localparam logic [15:0] DEFAULT_TIMEOUT_MS  = 16'd3000;
  localparam logic [19:0] NS_PER_MS           = 20'd1000000;
  localparam logic [21:0] FRESH_NS_PER_MS     = 22'd3000000;
  localparam logic [63:0] STEP_THRESHOLD_NS   = 64'd100000000;

  typedef struct packed {
    logic [1:0]  command;
    logic [3:0]  source_index;
    logic [7:0]  priority_req;
    logic [15:0] period_ms;
    logic [63:0] obs_utc_ns;
    logic [63:0] obs_local_ns;
    logic        pps_flag;
    logic [63:0] now_ns;
    logic [1:0]  ptp_state;
    logic [1:0]  ptp_source;
    logic signed [63:0] ptp_offset_ns;
  } tss_in_t;

  typedef struct packed {
    logic        status;
    logic [1:0]  sync_state;
    logic [1:0]  time_source;
    logic signed [63:0] offset_out_ns;
    logic [3:0]  selected_index;
    logic        selected_valid;
    logic        selected_pps;
    logic        step_request;
    logic [63:0] step_time_ns;
    logic        state_changed;
    logic [1:0]  health_level;
    logic        loss_of_lock;
  } tss_out_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_FETCH,
    S_PROJ,
    S_FINISH,
    S_OUT
  } tss_state_t;

endpackage

// ----- hdl/time_source_selector.sv -----
// time source selector top level: source table, scan sequencer and result register
// One item at a time. Register, observation and unknown items go through fetch and
// finish before the result is valid. A tick scans the table one entry per cycle
// through a shared multiply-compare unit (interval times 3 ms, then a 64-bit compare),
// then goes through project and finish before its result is valid. The next item is
// taken in the cycle after the result is accepted. The entry table is a memory with
// one read port; registered and observed flags live in flip-flops cleared at reset.
module time_source_selector #(
  parameter int NUM_SOURCES = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  tss_pkg::tss_in_t in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output tss_pkg::tss_out_t out_data,
  input  logic             cfg_we,
  input  logic [0:0]       cfg_index,
  input  logic [15:0]      cfg_data
);
  import tss_pkg::*;

  localparam int IW = (NUM_SOURCES > 1) ? $clog2(NUM_SOURCES) : 1;
  localparam int CW = $clog2(NUM_SOURCES + 1);

  // per-entry storage
  logic [NUM_SOURCES-1:0] reg_r;
  logic [NUM_SOURCES-1:0] obs_r;
  logic [7:0]  prio_mem [NUM_SOURCES];
  logic [15:0] ivl_mem  [NUM_SOURCES];
  logic [63:0] utc_mem  [NUM_SOURCES];
  logic [63:0] loc_mem  [NUM_SOURCES];
  logic [63:0] seen_mem [NUM_SOURCES];
  logic        pps_mem  [NUM_SOURCES];

  logic [15:0] timeout_r;
  logic        disc_r;
  tss_in_t     item_r;
  tss_state_t  state_r, state_nxt;
  logic [CW-1:0] cnt_r;
  logic [IW-1:0] rd_addr;
  logic [7:0]  rd_prio;
  logic [15:0] rd_ivl;
  logic [63:0] rd_utc, rd_loc, rd_seen;
  logic        rd_pps;
  logic        rd_reg_r;
  logic        rd_obs_r;
  logic        rd_vld_r;
  logic [IW-1:0] rd_idx_r;
  logic        best_v_r;
  logic [IW-1:0] best_r;
  logic [7:0]  best_prio_r;
  logic [63:0] last_live_r;
  logic [1:0]  cur_state_r, cur_src_r, rep_state_r;
  logic [63:0] cur_off_r;
  logic        disciplined_r;
  tss_out_t    out_r;
  logic        out_valid_r;
  logic        idx_ok;
  logic        fresh;
  logic [37:0] prod;

  assign idx_ok = ({5'd0, item_r.source_index} < 9'(NUM_SOURCES));

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r <= DEFAULT_TIMEOUT_MS;
      disc_r    <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_TIMEOUT: timeout_r <= cfg_data;
        CFG_DISC:    disc_r    <= cfg_data[0];
        default:     ;
      endcase
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:   if (in_valid && in_ready) state_nxt = S_FETCH;
      S_FETCH:  state_nxt = (item_r.command == CMD_TICK) ? S_SCAN : S_FINISH;
      S_SCAN:   if (cnt_r == CW'(NUM_SOURCES)) state_nxt = S_PROJ;
      S_PROJ:   state_nxt = S_FINISH;
      S_FINISH: state_nxt = S_OUT;
      S_OUT:    if (out_ready) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_ready = (state_r == S_IDLE) && !out_valid_r;
    if (state_r == S_PROJ) rd_addr = best_r;
    else if (state_r == S_SCAN) rd_addr = cnt_r[IW-1:0];
    else rd_addr = IW'(item_r.source_index);
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else state_r <= state_nxt;
  end

  // memory port: one write, one registered read
  always_ff @(posedge clk) begin
    if (state_r == S_FETCH && idx_ok) begin
      if (item_r.command == CMD_REGISTER) begin
        prio_mem[rd_addr] <= item_r.priority_req;
        ivl_mem[rd_addr]  <= (item_r.period_ms == 16'd0) ? DEFAULT_PERIOD_MS
                                                         : item_r.period_ms;
      end else if (item_r.command == CMD_OBSERVE && reg_r[rd_addr]) begin
        utc_mem[rd_addr]  <= item_r.obs_utc_ns;
        loc_mem[rd_addr]  <= item_r.obs_local_ns;
        pps_mem[rd_addr]  <= item_r.pps_flag;
        seen_mem[rd_addr] <= item_r.now_ns;
      end
    end
    rd_prio  <= prio_mem[rd_addr];
    rd_ivl   <= ivl_mem[rd_addr];
    rd_utc   <= utc_mem[rd_addr];
    rd_loc   <= loc_mem[rd_addr];
    rd_seen  <= seen_mem[rd_addr];
    rd_pps   <= pps_mem[rd_addr];
    rd_reg_r <= reg_r[rd_addr];
    rd_obs_r <= obs_r[rd_addr];
    rd_idx_r <= rd_addr;
  end

  // shared freshness unit: interval * 3 ms compared with age
  assign prod  = 38'(rd_ivl) * 38'(FRESH_NS_PER_MS);
  assign fresh = rd_reg_r && rd_obs_r && (rd_seen != 64'd0) && (rd_utc != 64'd0) &&
                 ((item_r.now_ns - rd_seen) <= 64'(prod));

  // main datapath
  always_ff @(posedge clk) begin
    logic [63:0] off;
    logic [63:0] mag;
    logic [1:0]  ns;
    tss_out_t    o;
    off = rd_utc + (item_r.now_ns - rd_loc) - item_r.now_ns;
    mag = off[63] ? (64'd0 - off) : off;
    ns  = cur_state_r;
    o   = out_r;
    if (!rst_n) begin
      reg_r         <= '0;
      obs_r         <= '0;
      cnt_r         <= '0;
      rd_vld_r      <= 1'b0;
      best_v_r      <= 1'b0;
      last_live_r   <= '0;
      cur_state_r   <= '0;
      cur_src_r     <= '0;
      cur_off_r     <= '0;
      disciplined_r <= 1'b0;
      rep_state_r   <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (in_valid && in_ready) item_r <= in_data;
          cnt_r    <= '0;
          best_v_r <= 1'b0;
          rd_vld_r <= 1'b0;
        end
        S_FETCH: begin
          o = '0;
          o.sync_state    = cur_state_r;
          o.time_source   = cur_src_r;
          o.offset_out_ns = cur_off_r;
          if (item_r.command == CMD_REGISTER && idx_ok) reg_r[rd_addr] <= 1'b1;
          if (item_r.command == CMD_OBSERVE && idx_ok && reg_r[rd_addr])
            obs_r[rd_addr] <= 1'b1;
          if (item_r.command == CMD_OBSERVE && !(idx_ok && reg_r[rd_addr]))
            o.status = 1'b1;
          out_r <= o;
        end
        S_SCAN: begin
          cnt_r    <= cnt_r + 1'b1;
          rd_vld_r <= 1'b1;
          if (rd_vld_r && fresh && (!best_v_r || rd_prio > best_prio_r)) begin
            best_v_r    <= 1'b1;
            best_r      <= rd_idx_r;
            best_prio_r <= rd_prio;
          end
        end
        S_PROJ: ;
        S_FINISH: begin
          if (item_r.command == CMD_TICK) begin
            if (best_v_r) begin
              o.selected_index = 4'(best_r);
              o.selected_valid = 1'b1;
              o.selected_pps   = rd_pps;
              last_live_r <= item_r.now_ns;
              if (disc_r && !(mag < STEP_THRESHOLD_NS && disciplined_r)) begin
                disciplined_r <= 1'b1;
                o.step_request = 1'b1;
                o.step_time_ns = rd_utc + (item_r.now_ns - rd_loc);
              end
              ns = ST_LOCKED;
              cur_src_r <= SRC_EXTERNAL;
              cur_off_r <= off;
              o.time_source   = SRC_EXTERNAL;
              o.offset_out_ns = off;
            end else if (last_live_r != 64'd0 &&
                         (item_r.now_ns - last_live_r) <
                         64'(36'(timeout_r) * 36'(NS_PER_MS))) begin
              ns = ST_HOLDOVER;
              cur_src_r <= SRC_EXTERNAL;
              o.time_source = SRC_EXTERNAL;
            end else begin
              ns = item_r.ptp_state;
              cur_src_r <= item_r.ptp_source;
              cur_off_r <= item_r.ptp_offset_ns;
              o.time_source   = item_r.ptp_source;
              o.offset_out_ns = item_r.ptp_offset_ns;
            end
            cur_state_r <= ns;
            o.sync_state = ns;
            if (ns != rep_state_r) begin
              o.state_changed = 1'b1;
              o.loss_of_lock  = (ns < rep_state_r);
              o.health_level  = (ns == ST_LOCKED) ? HEALTH_OK :
                                (ns == ST_HOLDOVER) ? HEALTH_WARNING
                                                    : HEALTH_DEGRADED;
              rep_state_r <= ns;
            end
            out_r <= o;
          end
          out_valid_r <= 1'b1;
        end
        S_OUT: if (out_ready) out_valid_r <= 1'b0;
        default: ;
      endcase
    end
  end

endmodule

// ----- test/time_source_selector_checker.sv -----
// checker for the time source selector: predicts each result item and compares it
`timescale 1ns / 1ps

module time_source_selector_checker (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_ready,
  input  tss_pkg::tss_in_t  in_data,
  input  logic              out_valid,
  input  logic              out_ready,
  input  tss_pkg::tss_out_t out_data,
  input  logic              cfg_we,
  input  logic [0:0]        cfg_index,
  input  logic [15:0]       cfg_data,
  output int                fail_count,
  output int                pending_count,
  output int                result_count,
  output int                locked_count
);
  import tss_pkg::*;

  // shadow copy of the source table and selector state
  logic        reg_flag [16];
  logic [7:0]  prio_tab [16];
  logic [15:0] ivl_tab [16];
  logic [63:0] utc_tab [16];
  logic [63:0] local_tab [16];
  logic [63:0] seen_tab [16];
  logic        pps_tab [16];
  logic [63:0] last_live;
  logic [1:0]  cur_state;
  logic [1:0]  cur_source;
  logic [63:0] cur_offset;
  logic        stepped;
  logic [1:0]  rep_state;
  logic [15:0] timeout_ms;
  logic        disc_en;

  tss_out_t expected_results [$];

  // compute the result item for one accepted input item and update the shadow state
  function automatic tss_out_t predict_selection(tss_in_t it);
    tss_out_t r;
    int best;
    logic [63:0] fresh, utc_now, off, mag;
    r = '0;
    best = -1;
    if (it.command == CMD_REGISTER) begin
      reg_flag[it.source_index] = 1'b1;
      prio_tab[it.source_index] = it.priority_req;
      ivl_tab[it.source_index] = (it.period_ms != 0) ? it.period_ms : DEFAULT_PERIOD_MS;
    end else if (it.command == CMD_OBSERVE) begin
      if (reg_flag[it.source_index]) begin
        utc_tab[it.source_index] = it.obs_utc_ns;
        local_tab[it.source_index] = it.obs_local_ns;
        pps_tab[it.source_index] = it.pps_flag;
        seen_tab[it.source_index] = it.now_ns;
      end else begin
        r.status = 1'b1;
      end
    end else if (it.command == CMD_TICK) begin
      // highest priority fresh entry, ties to lowest index
      for (int i = 0; i < 16; i++) begin
        if (reg_flag[i] && seen_tab[i] != 0 && utc_tab[i] != 0) begin
          fresh = 64'(ivl_tab[i]) * 64'd3000000;
          if (it.now_ns - seen_tab[i] <= fresh)
            if (best < 0 || prio_tab[i] > prio_tab[best]) best = i;
        end
      end
      if (best >= 0) begin
        utc_now = utc_tab[best] + (it.now_ns - local_tab[best]);
        off = utc_now - it.now_ns;
        r.selected_index = 4'(best);
        r.selected_valid = 1'b1;
        r.selected_pps = pps_tab[best];
        last_live = it.now_ns;
        if (disc_en) begin
          mag = off[63] ? (64'd0 - off) : off;
          if (!(mag < STEP_THRESHOLD_NS && stepped)) begin
            stepped = 1'b1;
            r.step_request = 1'b1;
            r.step_time_ns = utc_now;
          end
        end
        cur_source = SRC_EXTERNAL;
        cur_state = ST_LOCKED;
        cur_offset = off;
      end else if (last_live != 0 &&
                   it.now_ns - last_live < 64'(timeout_ms) * 64'd1000000) begin
        cur_source = SRC_EXTERNAL;
        cur_state = ST_HOLDOVER;
      end else begin
        cur_state = it.ptp_state;
        cur_source = it.ptp_source;
        cur_offset = it.ptp_offset_ns;
      end
      // state edge report
      if (cur_state != rep_state) begin
        r.state_changed = 1'b1;
        r.loss_of_lock = cur_state < rep_state;
        if (cur_state == ST_LOCKED) r.health_level = HEALTH_OK;
        else if (cur_state == ST_HOLDOVER) r.health_level = HEALTH_WARNING;
        else r.health_level = HEALTH_DEGRADED;
        rep_state = cur_state;
      end
    end
    r.sync_state = cur_state;
    r.time_source = cur_source;
    r.offset_out_ns = cur_offset;
    return r;
  endfunction

  // whole-item comparison against the oldest expectation, each field shown on a mismatch
  task automatic compare_result(tss_out_t exp_r, tss_out_t act);
    if (act !== exp_r) begin
      fail_count++;
      $display("%0t mismatch: expected st=%0d src=%0d off=%0d sel=%0d/%0b pps=%0b step=%0b/%0h",
               $time, exp_r.sync_state, exp_r.time_source, exp_r.offset_out_ns,
               exp_r.selected_index, exp_r.selected_valid, exp_r.selected_pps,
               exp_r.step_request, exp_r.step_time_ns);
      $display("  expected status=%0b chg=%0b health=%0d lol=%0b",
               exp_r.status, exp_r.state_changed, exp_r.health_level, exp_r.loss_of_lock);
      $display("%0t actual:   st=%0d src=%0d off=%0d sel=%0d/%0b pps=%0b step=%0b/%0h",
               $time, act.sync_state, act.time_source, act.offset_out_ns,
               act.selected_index, act.selected_valid, act.selected_pps,
               act.step_request, act.step_time_ns);
      $display("  actual   status=%0b chg=%0b health=%0d lol=%0b",
               act.status, act.state_changed, act.health_level, act.loss_of_lock);
    end
  endtask

  // watch configuration, input and result channels
  always @(posedge clk) begin
    tss_out_t exp_r;
    if (!rst_n) begin
      for (int i = 0; i < 16; i++) begin
        reg_flag[i] = 0; prio_tab[i] = 0; ivl_tab[i] = 0; utc_tab[i] = 0;
        local_tab[i] = 0; seen_tab[i] = 0; pps_tab[i] = 0;
      end
      last_live = 0; cur_state = 0; cur_source = 0; cur_offset = 0;
      stepped = 0; rep_state = 0;
      timeout_ms = DEFAULT_TIMEOUT_MS;
      disc_en = 0;
      fail_count = 0; result_count = 0; locked_count = 0;
      expected_results.delete();
      pending_count = 0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_TIMEOUT) timeout_ms = cfg_data;
        else disc_en = cfg_data[0];
      end
      if (in_valid && in_ready) begin
        exp_r = predict_selection(in_data);
        if (exp_r.selected_valid) locked_count++;
        expected_results.push_back(exp_r);
      end
      if (out_valid && out_ready) begin
        result_count++;
        if (expected_results.size() == 0) begin
          fail_count++;
          $display("%0t unexpected result item, actual st=%0d", $time, out_data.sync_state);
        end else begin
          compare_result(expected_results.pop_front(), out_data);
        end
      end
      pending_count = expected_results.size();
    end
  end
endmodule

// ----- test/time_source_selector_tb.sv -----
// testbench top for the time source selector: stimulus, configuration and verdict
`timescale 1ns / 1ps

module time_source_selector_tb;
  import tss_pkg::*;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  tss_in_t     in_data;
  logic        out_valid;
  logic        out_ready;
  tss_out_t    out_data;
  logic        cfg_we;
  logic [0:0]  cfg_index;
  logic [15:0] cfg_data;
  int          fail_count, pending_count, result_count, locked_count;
  int          cycle_count;
  int          send_idle_pct, recv_idle_pct;
  logic [63:0] now_base;

  time_source_selector u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  time_source_selector_checker u_checker (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending_count(pending_count),
    .result_count(result_count), .locked_count(locked_count)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // cycle limit watchdog
  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count > 900000) begin
        $display("** time_source_selector: FAILED **");
        $finish;
      end
    end
  end

  // receiver stalls at random
  always @(posedge clk) begin
    if (!rst_n) out_ready <= 1'b0;
    else out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // send one item and wait for its acceptance, with a random gap first
  // valid is left high after acceptance; the next call or the drain lowers it
  task automatic send_item(tss_in_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic write_reg(logic [0:0] idx, logic [15:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // let the block drain before touching configuration
  task automatic drain_block();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  function automatic tss_in_t random_item(logic [1:0] cmd);
    tss_in_t it;
    it = '0;
    it.command = cmd;
    it.source_index = 4'($urandom_range(15));
    it.priority_req = ($urandom_range(3) == 0) ? 8'd255 : 8'($urandom_range(255));
    case ($urandom_range(3))
      0: it.period_ms = 16'd0;
      1: it.period_ms = 16'hffff;
      default: it.period_ms = 16'($urandom_range(1, 400));
    endcase
    it.pps_flag = 1'($urandom_range(1));
    it.ptp_state = 2'($urandom_range(3));
    it.ptp_source = 2'($urandom_range(3));
    it.ptp_offset_ns = {$urandom, $urandom};
    // time advances in ms-scale steps so freshness and holdover both matter
    now_base = now_base + 64'($urandom_range(0, 1500)) * 64'd1000000 +
               64'($urandom_range(999));
    if ($urandom_range(19) == 0) now_base = {$urandom, $urandom};
    it.now_ns = now_base;
    it.obs_local_ns = now_base - 64'($urandom_range(0, 50000000));
    case ($urandom_range(4))
      0: it.obs_utc_ns = {$urandom, $urandom};
      1: it.obs_utc_ns = it.obs_local_ns + 64'($urandom_range(0, 99999999));
      2: it.obs_utc_ns = it.obs_local_ns - 64'($urandom_range(0, 500000000));
      default: it.obs_utc_ns = it.obs_local_ns + 64'($urandom_range(0, 1000)) * 64'd1000000;
    endcase
    if ($urandom_range(49) == 0) it.obs_local_ns = {$urandom, $urandom};
    return it;
  endfunction

  // directed items: extremes, every command, drops, holdover and fallback
  task automatic run_directed();
    tss_in_t it;
    it = random_item(CMD_OBSERVE);
    it.source_index = 4'd3;
    send_item(it);                          // observation of unregistered entry
    it = random_item(CMD_TICK);
    send_item(it);                          // tick with empty table
    it = random_item(CMD_RESERVED);
    send_item(it);                          // unknown command
    it = random_item(CMD_REGISTER);
    it.source_index = 4'd0; it.priority_req = 8'd0; it.period_ms = 16'd0;
    send_item(it);
    it.source_index = 4'd15; it.priority_req = 8'd255; it.period_ms = 16'hffff;
    send_item(it);
    it.source_index = 4'd7; it.priority_req = 8'd255; it.period_ms = 16'd10;
    send_item(it);                          // tie with entry 15
    it = random_item(CMD_OBSERVE);
    it.source_index = 4'd0; it.obs_utc_ns = '0;
    send_item(it);                          // utc zero counts as never observed
    it.command = CMD_TICK;
    send_item(it);
    it = random_item(CMD_OBSERVE);
    it.source_index = 4'd15; it.obs_utc_ns = '1; it.obs_local_ns = '0; it.pps_flag = 1'b1;
    send_item(it);
    it = random_item(CMD_OBSERVE);
    it.source_index = 4'd7; it.now_ns = now_base;
    send_item(it);
    it = random_item(CMD_TICK);
    it.now_ns = now_base;
    send_item(it);                          // tie goes to lowest index
    it.now_ns = now_base + 64'd40000000;
    send_item(it);                          // entry 7 stale, holdover or 15
    it.now_ns = now_base + 64'd200000000000000;
    it.ptp_offset_ns = 64'sh8000000000000000;
    it.ptp_state = ST_UNLOCKED; it.ptp_source = 2'd3;  // source code outside the list
    send_item(it);                          // everything stale, fallback
    it.ptp_offset_ns = 64'sh7fffffffffffffff; it.ptp_state = ST_LOCKED;
    send_item(it);
    it.ptp_state = ST_UNAVAILABLE; it.ptp_source = SRC_PTP;
    send_item(it);
  endtask

  // one random phase of well-formed traffic plus noise
  task automatic run_random(int count);
    tss_in_t it;
    int pick;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      if (pick < 15) it = random_item(CMD_REGISTER);
      else if (pick < 55) it = random_item(CMD_OBSERVE);
      else if (pick < 97) it = random_item(CMD_TICK);
      else it = random_item(CMD_RESERVED);
      send_item(it);
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_index = CFG_TIMEOUT;
    cfg_data = '0;
    send_idle_pct = 18;
    recv_idle_pct = 78;
    now_base = 64'd5000000000;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    run_directed();
    drain_block();
    write_reg(CFG_DISC, 16'd1);
    write_reg(CFG_TIMEOUT, 16'd1);
    run_random(380);

    drain_block();
    send_idle_pct = 78;
    recv_idle_pct = 18;
    write_reg(CFG_TIMEOUT, 16'hffff);
    write_reg(CFG_DISC, 16'd0);
    run_random(380);

    drain_block();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_reg(CFG_TIMEOUT, 16'd2500);
    write_reg(CFG_DISC, 16'd1);
    run_random(380);

    drain_block();
    $display("covered %0d result items, %0d ticks locked to a source,", result_count,
             locked_count);
    $display("across several timeout and discipline settings and idle patterns");
    if (fail_count == 0) begin
      $display("** time_source_selector: PASSED **");
    end else begin
      $display("** time_source_selector: FAILED **");
    end
    $finish;
  end
endmodule

// ----- files.f -----
hdl/tss_pkg.sv
hdl/time_source_selector.sv
test/time_source_selector_checker.sv
test/time_source_selector_tb.sv
